@@ hw/rtl/ffs_pkg.sv @@
`timescale 1ns / 1ps

package ffs_pkg;

  // Configuration address: six 16-bit registers in 32-bit words at byte offsets 0x00..0x14
  localparam int CFG_AW = 5;

  typedef enum logic [2:0] {
    CFG_MIN_TEMP     = 3'd0,
    CFG_MAX_TEMP     = 3'd1,
    CFG_OT_LIMIT     = 3'd2,
    CFG_OC_LIMIT     = 3'd3,
    CFG_STALL_TMO    = 3'd4,
    CFG_RECOVERY     = 3'd5
  } cfg_idx_t;

  localparam logic signed [15:0] RST_MIN_TEMP  = -16'sd640;
  localparam logic signed [15:0] RST_MAX_TEMP  = 16'sd2400;
  localparam logic signed [15:0] RST_OT_LIMIT  = 16'sd1600;
  localparam logic [15:0]        RST_OC_LIMIT  = 16'd2000;
  localparam logic [15:0]        RST_STALL_TMO = 16'd2000;
  localparam logic [15:0]        RST_RECOVERY  = 16'd5;

  typedef enum logic [2:0] {
    FLT_NONE         = 3'd0,
    FLT_SENSOR       = 3'd1,
    FLT_OVER_TEMP    = 3'd2,
    FLT_OVER_CURRENT = 3'd3,
    FLT_STALL        = 3'd4
  } fault_code_t;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_SAFE   = 2'd1,
    ST_FAULT  = 2'd2
  } sys_state_t;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_HIGH = 2'd3;
  localparam logic [6:0] DUTY_ZERO = 7'd0;
  localparam logic [6:0] DUTY_FULL = 7'd100;

  typedef struct packed {
    logic signed [15:0] min_temp;
    logic signed [15:0] max_temp;
    logic signed [15:0] ot_limit;
    logic [15:0]        oc_limit;
    logic [15:0]        stall_tmo;
    logic [15:0]        recovery;
  } ffs_cfg_t;

  typedef struct packed {
    logic               sensor_valid;
    logic signed [15:0] temperature;
    logic [15:0]        current_ma;
    logic               rpm_available;
    logic [15:0]        rpm;
    logic [1:0]         command_mode;
    logic [6:0]         command_duty;
    logic [15:0]        elapsed_ms;
  } ffs_item_t;

  typedef struct packed {
    logic [1:0]  fan_mode;
    logic [6:0]  duty_percent;
    fault_code_t fault_code;
    sys_state_t  system_state;
  } ffs_result_t;

  // Fixed fan output forced by each fault
  function automatic ffs_result_t fault_output(fault_code_t f);
    ffs_result_t r;
    r.fault_code = f;
    unique case (f)
      FLT_SENSOR: begin
        r.fan_mode     = MODE_HIGH;
        r.duty_percent = DUTY_FULL;
        r.system_state = ST_SAFE;
      end
      FLT_OVER_TEMP: begin
        r.fan_mode     = MODE_HIGH;
        r.duty_percent = DUTY_FULL;
        r.system_state = ST_FAULT;
      end
      FLT_OVER_CURRENT, FLT_STALL: begin
        r.fan_mode     = MODE_OFF;
        r.duty_percent = DUTY_ZERO;
        r.system_state = ST_FAULT;
      end
      default: begin
        r.fan_mode     = MODE_OFF;
        r.duty_percent = DUTY_ZERO;
        r.fault_code   = FLT_NONE;
        r.system_state = ST_NORMAL;
      end
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/ffs_in_if.sv @@
`timescale 1ns / 1ps

interface ffs_in_if;
  logic               valid;
  logic               ready;
  logic               sensor_valid;
  logic signed [15:0] temperature;
  logic [15:0]        current_ma;
  logic               rpm_available;
  logic [15:0]        rpm;
  logic [1:0]         command_mode;
  logic [6:0]         command_duty;
  logic [15:0]        elapsed_ms;

  modport source (
    output valid, sensor_valid, temperature, current_ma, rpm_available, rpm,
           command_mode, command_duty, elapsed_ms,
    input  ready
  );

  modport sink (
    input  valid, sensor_valid, temperature, current_ma, rpm_available, rpm,
           command_mode, command_duty, elapsed_ms,
    output ready
  );
endinterface

@@ hw/rtl/ffs_out_if.sv @@
`timescale 1ns / 1ps

interface ffs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] fan_mode;
  logic [6:0] duty_percent;
  logic [2:0] fault_code;
  logic [1:0] system_state;

  modport source (
    output valid, fan_mode, duty_percent, fault_code, system_state,
    input  ready
  );

  modport sink (
    input  valid, fan_mode, duty_percent, fault_code, system_state,
    output ready
  );
endinterface

@@ hw/rtl/ffs_cfg_regs.sv @@
`timescale 1ns / 1ps

module ffs_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ffs_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output ffs_pkg::ffs_cfg_t          cfg
);
  import ffs_pkg::*;

  ffs_cfg_t cfg_r;
  cfg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = cfg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_temp  <= RST_MIN_TEMP;
      cfg_r.max_temp  <= RST_MAX_TEMP;
      cfg_r.ot_limit  <= RST_OT_LIMIT;
      cfg_r.oc_limit  <= RST_OC_LIMIT;
      cfg_r.stall_tmo <= RST_STALL_TMO;
      cfg_r.recovery  <= RST_RECOVERY;
    end else if (wr_en) begin
      unique case (idx)
        CFG_MIN_TEMP:  cfg_r.min_temp  <= pwdata[15:0];
        CFG_MAX_TEMP:  cfg_r.max_temp  <= pwdata[15:0];
        CFG_OT_LIMIT:  cfg_r.ot_limit  <= pwdata[15:0];
        CFG_OC_LIMIT:  cfg_r.oc_limit  <= pwdata[15:0];
        CFG_STALL_TMO: cfg_r.stall_tmo <= pwdata[15:0];
        CFG_RECOVERY:  cfg_r.recovery  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      CFG_MIN_TEMP:  prdata = {16'd0, cfg_r.min_temp};
      CFG_MAX_TEMP:  prdata = {16'd0, cfg_r.max_temp};
      CFG_OT_LIMIT:  prdata = {16'd0, cfg_r.ot_limit};
      CFG_OC_LIMIT:  prdata = {16'd0, cfg_r.oc_limit};
      CFG_STALL_TMO: prdata = {16'd0, cfg_r.stall_tmo};
      CFG_RECOVERY:  prdata = {16'd0, cfg_r.recovery};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

@@ hw/rtl/ffs_fault_core.sv @@
`timescale 1ns / 1ps

module ffs_fault_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  ffs_pkg::ffs_item_t   item,
  input  ffs_pkg::ffs_cfg_t    cfg,
  output ffs_pkg::ffs_result_t result
);
  import ffs_pkg::*;

  // Stall timer only needs to resolve against a 16-bit timeout, so it
  // saturates at all ones of 16 bits.
  logic [15:0] stall_r, stall_nxt;
  logic [15:0] rec_r, rec_nxt;
  fault_code_t held_r, held_nxt;

  logic        sensor_flt, oc_flt, ot_flt, stalling;
  logic [16:0] stall_sum;
  logic [15:0] stall_sat;
  logic [15:0] rec_inc;
  logic        release_now;
  fault_code_t active;
  logic [6:0]  duty_sat;

  assign sensor_flt = !item.sensor_valid || (item.temperature < cfg.min_temp) ||
                      (item.temperature > cfg.max_temp);
  assign oc_flt     = item.current_ma > cfg.oc_limit;
  assign ot_flt     = item.temperature >= cfg.ot_limit;
  assign stalling   = item.rpm_available && (item.command_duty != DUTY_ZERO) &&
                      (item.rpm == 16'd0);
  assign stall_sum  = {1'b0, stall_r} + {1'b0, item.elapsed_ms};
  assign stall_sat  = stall_sum[16] ? 16'hFFFF : stall_sum[15:0];
  assign rec_inc    = rec_r + 16'd1;
  assign release_now = rec_inc >= cfg.recovery;
  assign duty_sat   = (item.command_duty > DUTY_FULL) ? DUTY_FULL : item.command_duty;

  always_comb begin
    active    = FLT_NONE;
    stall_nxt = stall_r;
    priority if (sensor_flt) begin
      active = FLT_SENSOR;
    end else if (oc_flt) begin
      active = FLT_OVER_CURRENT;
    end else if (ot_flt) begin
      active = FLT_OVER_TEMP;
    end else if (stalling) begin
      stall_nxt = stall_sat;
      if (stall_sat >= cfg.stall_tmo) active = FLT_STALL;
    end else begin
      stall_nxt = 16'd0;
    end
  end

  always_comb begin
    held_nxt = held_r;
    rec_nxt  = rec_r;
    result.fan_mode     = item.command_mode;
    result.duty_percent = duty_sat;
    result.fault_code   = FLT_NONE;
    result.system_state = ST_NORMAL;
    if (active != FLT_NONE) begin
      held_nxt = active;
      rec_nxt  = 16'd0;
      result   = fault_output(active);
    end else if (held_r != FLT_NONE) begin
      if (release_now) begin
        held_nxt = FLT_NONE;
        rec_nxt  = 16'd0;
      end else begin
        rec_nxt  = rec_inc;
        result   = fault_output(held_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stall_r <= 16'd0;
      rec_r   <= 16'd0;
      held_r  <= FLT_NONE;
    end else if (advance) begin
      stall_r <= stall_nxt;
      rec_r   <= rec_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

@@ hw/rtl/fan_fault_supervisor.sv @@
`timescale 1ns / 1ps
// Fan fault supervisor.
// in_s carries one control period per word: sensor validity, temperature
// (signed 1/16 C), current, rpm feedback, the normal fan command and the
// elapsed milliseconds. out_m returns exactly one word per period: fan mode,
// duty, fault code and system state. The APB port (psel ... pready) holds six
// 16-bit limits at byte offsets 0x00..0x14; write it only while idle.
// A word accepted on in_s lands in the input register, is evaluated by the
// fault core and is shown on out_m from the result register.
// Throughput: one word per cycle while out_m is ready, set by the single
// evaluation stage between input and result registers, where fault state updates.
// When out_m stalls, the result register holds and the input register still
// takes one more word; in_s.ready drops only once both are full.
// Reset (rst_n low, synchronous) empties both registers, clears the stall
// timer, recovery count and latched fault, and restores default limits.
module fan_fault_supervisor (
  input  logic                       clk,
  input  logic                       rst_n,
  ffs_in_if.sink                     in_s,
  ffs_out_if.source                  out_m,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ffs_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import ffs_pkg::*;

  ffs_cfg_t    cfg;
  ffs_item_t   item_r;
  logic        item_vld_r;
  ffs_result_t res_r;
  ffs_result_t core_res;
  logic        res_vld_r;
  logic        advance;

  ffs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the held word when the result register is empty or draining.
  assign advance    = item_vld_r && (!res_vld_r || out_m.ready);
  assign in_s.ready = !item_vld_r || advance;

  ffs_fault_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_r),
    .cfg     (cfg),
    .result  (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_s.ready) item_vld_r <= in_s.valid;
      if (advance) begin
        res_vld_r <= 1'b1;
      end else if (out_m.ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers: capture on accept, no reset needed.
  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) begin
      item_r.sensor_valid  <= in_s.sensor_valid;
      item_r.temperature   <= in_s.temperature;
      item_r.current_ma    <= in_s.current_ma;
      item_r.rpm_available <= in_s.rpm_available;
      item_r.rpm           <= in_s.rpm;
      item_r.command_mode  <= in_s.command_mode;
      item_r.command_duty  <= in_s.command_duty;
      item_r.elapsed_ms    <= in_s.elapsed_ms;
    end
    if (advance) res_r <= core_res;
  end

  assign out_m.valid        = res_vld_r;
  assign out_m.fan_mode     = res_r.fan_mode;
  assign out_m.duty_percent = res_r.duty_percent;
  assign out_m.fault_code   = res_r.fault_code;
  assign out_m.system_state = res_r.system_state;

endmodule

@@ hw/rtl/ffs_checker.sv @@
`timescale 1ns / 1ps

module ffs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] fan_mode,
  input logic [6:0] duty_percent,
  input logic [2:0] fault_code,
  input logic [1:0] system_state
);
  import ffs_pkg::*;

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({fan_mode, duty_percent, fault_code, system_state}))
    else $error("stalled result changed or dropped");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> duty_percent <= DUTY_FULL)
    else $error("duty above full scale");

  a_normal_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fault_code == FLT_NONE |-> system_state == ST_NORMAL)
    else $error("no fault but state not normal");

  a_fault_forced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fault_code != FLT_NONE |-> system_state != ST_NORMAL &&
      ((fan_mode == MODE_HIGH && duty_percent == DUTY_FULL) ||
       (fan_mode == MODE_OFF && duty_percent == DUTY_ZERO)))
    else $error("fault word without forced fan output");

endmodule

bind fan_fault_supervisor ffs_checker u_ffs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_m.valid),
  .out_ready    (out_m.ready),
  .fan_mode     (out_m.fan_mode),
  .duty_percent (out_m.duty_percent),
  .fault_code   (out_m.fault_code),
  .system_state (out_m.system_state)
);
